// ----- rtl/uartrx_pkg.sv -----
package uartrx_pkg;

  localparam int CLK_HZ             = 100000000;
  localparam int BAUD               = 115200;
  localparam int MAX_DATA_BITS_DEF  = 9;
  localparam int TIMER_WIDTH_DEF    = 16;

  localparam int BIT_TIME_W  = 16;
  localparam int DATA_BITS_W = 4;
  localparam int STOP_BITS_W = 2;
  localparam int PAR_MODE_W  = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IDX_W       = 4;
  localparam int CHAR_W      = 9;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [BIT_TIME_W-1:0]  BIT_TIME_RST    = BIT_TIME_W'(CLK_HZ / BAUD);
  localparam logic [DATA_BITS_W-1:0] DATA_BITS_RST   = 4'd8;
  localparam logic [STOP_BITS_W-1:0] STOP_BITS_RST   = 2'd1;
  localparam logic [PAR_MODE_W-1:0]  PARITY_MODE_RST = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BITS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 2'd3;

  localparam logic [PAR_MODE_W-1:0] PAR_ODD  = 2'd1;
  localparam logic [PAR_MODE_W-1:0] PAR_EVEN = 2'd2;

  typedef struct packed {
    logic [BIT_TIME_W-1:0]  bit_time;
    logic [DATA_BITS_W-1:0] data_bits;
    logic [STOP_BITS_W-1:0] stop_bits;
    logic [PAR_MODE_W-1:0]  parity_mode;
  } cfg_t;

  typedef struct packed {
    logic              parity_error;
    logic [CHAR_W-1:0] char_data;
  } res_t;

endpackage

// ----- rtl/uartrx_core.sv -----
module uartrx_core #(
  parameter int MAX_DATA_BITS = uartrx_pkg::MAX_DATA_BITS_DEF,
  parameter int TIMER_WIDTH   = uartrx_pkg::TIMER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_vld,
  input  logic               line,
  input  uartrx_pkg::cfg_t   cfg,
  output logic               res_vld,
  output uartrx_pkg::res_t   res
);

  localparam int IW = uartrx_pkg::IDX_W;
  localparam int CW = uartrx_pkg::CHAR_W;
  localparam int TW = TIMER_WIDTH;
  localparam int MW = MAX_DATA_BITS;

  localparam logic [2:0] PH_WAIT_HIGH   = 3'd0;
  localparam logic [2:0] PH_WAIT_START  = 3'd1;
  localparam logic [2:0] PH_CHECK_START = 3'd2;
  localparam logic [2:0] PH_RECEIVE     = 3'd3;
  localparam logic [2:0] PH_PARITY      = 3'd4;
  localparam logic [2:0] PH_STOP        = 3'd5;

  logic [2:0]    phase_r, phase_nxt;
  logic [TW-1:0] bit_timer_r, bit_timer_nxt;
  logic [IW-1:0] bit_index_r, bit_index_nxt;
  logic [MW-1:0] shift_word_r, shift_word_nxt;
  logic          parity_ok_r, parity_ok_nxt;

  logic [IW:0]   eff_data;
  logic [IW:0]   eff_stop;
  logic [IW-1:0] idx_inc;
  logic          par_on;
  logic          exp_par;

  always_comb begin
    if (cfg.data_bits == '0) begin
      eff_data = (IW+1)'(1);
    end else if ({1'b0, cfg.data_bits} > (IW+1)'(MW)) begin
      eff_data = (IW+1)'(MW);
    end else begin
      eff_data = {1'b0, cfg.data_bits};
    end
    if (cfg.stop_bits == 2'd0) begin
      eff_stop = (IW+1)'(1);
    end else if (cfg.stop_bits == 2'd3) begin
      eff_stop = (IW+1)'(2);
    end else begin
      eff_stop = (IW+1)'(cfg.stop_bits);
    end
    par_on  = (cfg.parity_mode == uartrx_pkg::PAR_ODD) ||
              (cfg.parity_mode == uartrx_pkg::PAR_EVEN);
    exp_par = (^shift_word_r) ^ (cfg.parity_mode == uartrx_pkg::PAR_ODD);
    idx_inc = bit_index_r + IW'(1);
  end

  always_comb begin
    phase_nxt      = phase_r;
    bit_timer_nxt  = bit_timer_r;
    bit_index_nxt  = bit_index_r;
    shift_word_nxt = shift_word_r;
    parity_ok_nxt  = parity_ok_r;
    res_vld        = 1'b0;
    res.char_data    = CW'(shift_word_r);
    res.parity_error = ~parity_ok_r;
    if (phase_r == PH_WAIT_HIGH) begin
      if (line) phase_nxt = PH_WAIT_START;
    end else if (phase_r == PH_WAIT_START) begin
      if (!line) begin
        phase_nxt     = PH_CHECK_START;
        bit_timer_nxt = TW'(cfg.bit_time >> 1);
      end
    end else if (phase_r > PH_STOP) begin
      phase_nxt = PH_WAIT_HIGH;
    end else if (bit_timer_r > TW'(1)) begin
      bit_timer_nxt = bit_timer_r - TW'(1);
    end else begin
      bit_timer_nxt = '0;
      unique case (phase_r)
        PH_CHECK_START: begin
          if (!line) begin
            phase_nxt      = PH_RECEIVE;
            bit_index_nxt  = '0;
            shift_word_nxt = '0;
            parity_ok_nxt  = 1'b1;
            bit_timer_nxt  = TW'(cfg.bit_time);
          end else begin
            phase_nxt = PH_WAIT_START;
          end
        end
        PH_RECEIVE: begin
          for (int i = 0; i < MW; i++) begin
            if (bit_index_r == IW'(i) && line) shift_word_nxt[i] = 1'b1;
          end
          bit_index_nxt = idx_inc;
          if ({1'b0, idx_inc} >= eff_data) begin
            phase_nxt     = par_on ? PH_PARITY : PH_STOP;
            bit_index_nxt = '0;
          end
          bit_timer_nxt = TW'(cfg.bit_time);
        end
        PH_PARITY: begin
          parity_ok_nxt = (line == exp_par);
          phase_nxt     = PH_STOP;
          bit_timer_nxt = TW'(cfg.bit_time);
        end
        default: begin
          if (line) begin
            bit_index_nxt = idx_inc;
            if ({1'b0, idx_inc} >= eff_stop) begin
              phase_nxt     = PH_WAIT_START;
              bit_index_nxt = '0;
              res_vld       = item_vld;
            end else begin
              bit_timer_nxt = TW'(cfg.bit_time);
            end
          end else begin
            phase_nxt     = PH_WAIT_HIGH;
            bit_index_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_HIGH;
      bit_timer_r  <= '0;
      bit_index_r  <= '0;
      shift_word_r <= '0;
      parity_ok_r  <= 1'b1;
    end else if (item_vld) begin
      phase_r      <= phase_nxt;
      bit_timer_r  <= bit_timer_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_word_r <= shift_word_nxt;
      parity_ok_r  <= parity_ok_nxt;
    end
  end

  a_res_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> phase_r == PH_STOP)
    else $error("result outside stop phase");

  a_res_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> phase_r == PH_WAIT_START && bit_index_r == '0)
    else $error("no return to wait after result");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT_HIGH || phase_r == PH_WAIT_START) |-> bit_timer_r == '0)
    else $error("timer running while idle");

endmodule

// ----- rtl/uartrx_outbuf.sv -----
module uartrx_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uartrx_pkg::res_t push_data,
  output logic             space,
  output logic             out_vld,
  input  logic             out_rdy,
  output uartrx_pkg::res_t out_data
);

  logic             main_vld_r, main_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  uartrx_pkg::res_t main_r, main_nxt;
  uartrx_pkg::res_t skid_r, skid_nxt;
  logic             pop;

  assign pop      = main_vld_r & out_rdy;
  assign space    = ~skid_vld_r;
  assign out_vld  = main_vld_r;
  assign out_data = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!main_vld_r || pop) begin
      main_vld_nxt = push;
      if (push) main_nxt = push_data;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid holds an item while output is empty");

endmodule

// ----- rtl/uart_receiver_top.sv -----
// A result goes into the output register, or into the skid stage while that one is occupied.
// Throughput: one item per cycle while in_tready is high; the state machine updates on every accepted item.
// in_tready drops only while two results wait in the output register and skid stage.
// Reset (rst_n low, synchronous): state to waiting for idle line, output stage empty,
// configuration back to bit_time 868, 8 data bits, 1 stop bit, no parity.
module uart_receiver_top #(
  parameter int MAX_DATA_BITS = uartrx_pkg::MAX_DATA_BITS_DEF,
  parameter int TIMER_WIDTH   = uartrx_pkg::TIMER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [uartrx_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] line_level
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [uartrx_pkg::OUT_TDATA_W-1:0] out_tdata,  // [8:0] char_data, [9] parity_error
  input  logic                               cfg_we,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uartrx_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int OW = uartrx_pkg::OUT_TDATA_W;

  uartrx_pkg::cfg_t cfg_r;
  uartrx_pkg::res_t core_res;
  uartrx_pkg::res_t buf_res;
  logic             core_res_vld;
  logic             in_acc;

  assign in_acc = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_time    <= uartrx_pkg::BIT_TIME_RST;
      cfg_r.data_bits   <= uartrx_pkg::DATA_BITS_RST;
      cfg_r.stop_bits   <= uartrx_pkg::STOP_BITS_RST;
      cfg_r.parity_mode <= uartrx_pkg::PARITY_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uartrx_pkg::REG_BIT_TIME:
          cfg_r.bit_time <= cfg_wdata[uartrx_pkg::BIT_TIME_W-1:0];
        uartrx_pkg::REG_DATA_BITS:
          cfg_r.data_bits <= cfg_wdata[uartrx_pkg::DATA_BITS_W-1:0];
        uartrx_pkg::REG_STOP_BITS:
          cfg_r.stop_bits <= cfg_wdata[uartrx_pkg::STOP_BITS_W-1:0];
        uartrx_pkg::REG_PARITY_MODE:
          cfg_r.parity_mode <= cfg_wdata[uartrx_pkg::PAR_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  uartrx_core #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_acc),
    .line     (in_tdata[0]),
    .cfg      (cfg_r),
    .res_vld  (core_res_vld),
    .res      (core_res)
  );

  uartrx_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_res_vld),
    .push_data (core_res),
    .space     (in_tready),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_data  (buf_res)
  );

  assign out_tdata = OW'(buf_res);

endmodule
